@@ src/lru_pkg.sv @@
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and constants for the LRU page replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

  localparam int FRAMES    = 4;
  localparam int PAGE_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam int FAULT_BITS = 32;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  localparam int CFG_W      = 3;
  localparam int CFG_RESET  = 4;
  localparam int OUT_IDX_W  = 2;
  localparam int OUT_PAGE_W = 16;

  localparam int IN_DATA_W  = 16;
  // hit, frame_index, evicted_valid, evicted_page, fault_count -> 52 bits
  localparam int OUT_FIELDS_W = 1 + OUT_IDX_W + 1 + OUT_PAGE_W + FAULT_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } lru_state_t;

  typedef struct packed {
    logic load;    // capture the incoming page
    logic commit;  // update frames and write the result register
  } lru_cmd_t;

  typedef struct packed {
    logic out_full;  // result register holds an item not yet taken
  } lru_sts_t;

endpackage

`default_nettype wire

@@ src/lru_ctrl.sv @@
// ----------------------------------------------------------------------------
// lru_ctrl
// Two-state controller: take a reference, then commit it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_ctrl
  import lru_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire lru_sts_t sts,
  output lru_cmd_t      cmd
);

  lru_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // wait while the previous result is still stalled
        if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/lru_dp.sv @@
// ----------------------------------------------------------------------------
// lru_dp
// Frame table, timestamps, counters, lookup/victim logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_dp
  import lru_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lru_cmd_t              cmd,
  output lru_sts_t                   sts,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [CFG_W-1:0]     frames_in_use_r;
  logic [PAGE_BITS-1:0] page_r;

  logic [PAGE_BITS-1:0] frame_page_r [FRAMES];
  logic [FRAMES-1:0]    frame_valid_r, frame_valid_nxt;
  logic [TIME_BITS-1:0] frame_last_use_r [FRAMES];
  logic [TIME_BITS-1:0] ref_cnt_r;
  logic [FAULT_BITS-1:0] fault_cnt_r, fault_cnt_nxt;

  logic                  out_valid_r;
  logic                  hit_r;
  logic [OUT_IDX_W-1:0]  idx_r;
  logic                  ev_valid_r;
  logic [OUT_PAGE_W-1:0] ev_page_r;
  logic [FAULT_BITS-1:0] fault_out_r;

  // lookup and victim selection
  logic [CNT_W-1:0]     n_act;
  logic                 found, empty;
  logic [FIDX_W-1:0]    hit_idx, empty_idx, old_idx, slot;
  logic [TIME_BITS-1:0] best;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;

  always_comb begin
    // zero acts as one, anything above the table size as the table size
    if (frames_in_use_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(frames_in_use_r) > FRAMES) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(frames_in_use_r);
    end

    found     = 1'b0;
    hit_idx   = '0;
    empty     = 1'b0;
    empty_idx = '0;
    old_idx   = '0;
    best      = frame_last_use_r[0];
    for (int j = 0; j < FRAMES; j++) begin
      if (CNT_W'(j) < n_act) begin
        if (!found && frame_valid_r[j] && frame_page_r[j] == page_r) begin
          found   = 1'b1;
          hit_idx = FIDX_W'(j);
        end
        if (!empty && !frame_valid_r[j]) begin
          empty     = 1'b1;
          empty_idx = FIDX_W'(j);
        end
        if (frame_last_use_r[j] < best) begin
          best    = frame_last_use_r[j];
          old_idx = FIDX_W'(j);
        end
      end
    end

    ev_valid = 1'b0;
    ev_page  = '0;
    if (found) begin
      slot = hit_idx;
    end else if (empty) begin
      slot = empty_idx;
    end else begin
      slot     = old_idx;
      ev_valid = 1'b1;
      ev_page  = frame_page_r[old_idx];
    end

    fault_cnt_nxt = fault_cnt_r;
    if (!found && fault_cnt_r != '1) begin
      fault_cnt_nxt = fault_cnt_r + FAULT_BITS'(1);
    end

    frame_valid_nxt       = frame_valid_r;
    frame_valid_nxt[slot] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_W'(CFG_RESET);
      frame_valid_r   <= '0;
      ref_cnt_r       <= '0;
      fault_cnt_r     <= '0;
      out_valid_r     <= 1'b0;
      for (int j = 0; j < FRAMES; j++) begin
        frame_last_use_r[j] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        frames_in_use_r <= cfg_data;
      end
      if (cmd.commit) begin
        frame_valid_r          <= frame_valid_nxt;
        frame_last_use_r[slot] <= ref_cnt_r;
        fault_cnt_r            <= fault_cnt_nxt;
        if (ref_cnt_r != '1) begin
          ref_cnt_r <= ref_cnt_r + TIME_BITS'(1);
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_tdata[PAGE_BITS-1:0];
    end
    if (cmd.commit) begin
      frame_page_r[slot] <= page_r;
      hit_r              <= found;
      idx_r              <= OUT_IDX_W'(slot);
      ev_valid_r         <= ev_valid;
      ev_page_r          <= OUT_PAGE_W'(ev_page);
      fault_out_r        <= fault_cnt_nxt;
    end
  end

  assign sts.out_full = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                         fault_out_r, ev_page_r, ev_valid_r, idx_r, hit_r};

endmodule

`default_nettype wire

@@ src/lru_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative LRU page replacement over up to four frames.
// ----------------------------------------------------------------------------
// Operation: the accepted page is captured, then lookup/update/commit writes the
//   result register; the commit is held while the previous result waits.
//   No new item is taken until the current one commits, but a new item is
//   taken while the previous result waits on out_tready.
// Reset (rst_n low, synchronous): all frames empty, timestamps and counters
//   zero, frames_in_use = 4. cfg_ready is always high.
`default_nettype none

module lru_page_replacement_unit
  import lru_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items: [15:0] page_number
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // results: [0] hit, [2:1] frame_index, [3] evicted_valid,
  //   [19:4] evicted_page, [51:20] fault_count, [55:52] zero
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // configuration: [2:0] frames_in_use
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  lru_cmd_t cmd;
  lru_sts_t sts;

  assign cfg_ready = 1'b1;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lru_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_page_replacement_unit. Page references go in on
// the input stream. A behavioral LRU predictor works out hit, frame, victim and
// fault count for each accepted item, and a monitor checks every result in
// order. The frame count is changed between runs of items while the unit is idle.
// Phases vary the source and sink stall rates, and one phase holds the sink
// off long enough to back up the input.
// ----------------------------------------------------------------------------

module testbench;
  import lru_pkg::*;

  localparam int LATENCY     = 2;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    logic                   hit;
    logic [OUT_IDX_W-1:0]   frame;
    logic                   evicted;
    logic [OUT_PAGE_W-1:0]  evicted_page;
    logic [FAULT_BITS-1:0]  faults;
  } lookup_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  // predictor state
  logic [PAGE_BITS-1:0]   resident_page [FRAMES];
  logic                   resident_valid [FRAMES];
  logic [TIME_BITS-1:0]   last_touch [FRAMES];
  logic [TIME_BITS-1:0]   touch_count;
  logic [FAULT_BITS-1:0]  fault_total;
  logic [CFG_W-1:0]       frames_cfg;

  lookup_result_t         expected_results[$];

  int                     error_count = 0;
  int                     sender_idle_pct = 0;
  int                     receiver_idle_pct = 0;
  int                     hold_request = 0;
  int                     hold_left = 0;
  int                     quiet_cycles = 0;
  logic [PAGE_BITS-1:0]   hot_pages [8];
  int                     hot_count = 1;

  lru_page_replacement_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] page_number
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [0] hit, [2:1] frame_index, [3] evicted_valid,
                               // [19:4] evicted_page, [51:20] fault_count
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // [2:0] frames_in_use
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (error_count < MAX_PRINTS)
      $display("%0t mismatch: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    error_count++;
  endtask

  function automatic void clear_predictor();
    for (int i = 0; i < FRAMES; i++) begin
      resident_page[i] = '0;
      resident_valid[i] = 1'b0;
      last_touch[i] = '0;
    end
    touch_count = '0;
    fault_total = '0;
    frames_cfg = CFG_W'(CFG_RESET);
  endfunction

  function automatic lookup_result_t lru_predict(input logic [PAGE_BITS-1:0] page);
    lookup_result_t r;
    int active;
    int slot;
    bit found;
    bit has_empty;
    logic [TIME_BITS-1:0] now;
    now = touch_count;
    active = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    slot = 0;
    found = 1'b0;
    has_empty = 1'b0;
    r.evicted = 1'b0;
    r.evicted_page = '0;
    for (int i = 0; i < active; i++)
      if (!found && resident_valid[i] && resident_page[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    if (!found) begin
      if (fault_total != '1)
        fault_total = fault_total + 1'b1;
      for (int i = 0; i < active; i++)
        if (!has_empty && !resident_valid[i]) begin
          has_empty = 1'b1;
          slot = i;
        end
      if (!has_empty) begin
        // oldest stamp wins, strict compare keeps ties on the lowest index
        slot = 0;
        for (int i = 1; i < active; i++)
          if (last_touch[i] < last_touch[slot])
            slot = i;
        r.evicted = 1'b1;
        r.evicted_page = resident_page[slot];
      end
      resident_page[slot] = page;
      resident_valid[slot] = 1'b1;
    end
    last_touch[slot] = now;
    if (touch_count != '1)
      touch_count = touch_count + 1'b1;
    r.hit = found;
    r.frame = OUT_IDX_W'(slot);
    r.faults = fault_total;
    return r;
  endfunction

  // ---- drivers ----

  task automatic send_page(input logic [PAGE_BITS-1:0] page);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= page;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(lru_predict(page));
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] count);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frames_cfg = count;
  endtask

  function automatic void refresh_hot_pages();
    hot_count = $urandom_range(1, 8);
    for (int i = 0; i < 8; i++)
      case ($urandom_range(9))
        0:       hot_pages[i] = '0;
        1:       hot_pages[i] = '1;
        default: hot_pages[i] = PAGE_BITS'($urandom);
      endcase
  endfunction

  function automatic logic [PAGE_BITS-1:0] pick_page();
    if ($urandom_range(99) < 85)
      return hot_pages[$urandom_range(hot_count - 1)];
    return PAGE_BITS'($urandom);
  endfunction

  // ---- result side ----

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin : check_result
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding", '0, 64'(out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.hit)
          report_mismatch("hit", want.hit, out_tdata[0]);
        if (out_tdata[2:1] !== want.frame)
          report_mismatch("frame_index", want.frame, out_tdata[2:1]);
        if (out_tdata[3] !== want.evicted)
          report_mismatch("evicted_valid", want.evicted, out_tdata[3]);
        if (out_tdata[19:4] !== want.evicted_page)
          report_mismatch("evicted_page", want.evicted_page, out_tdata[19:4]);
        if (out_tdata[51:20] !== want.faults)
          report_mismatch("fault_count", want.faults, out_tdata[51:20]);
        if (out_tdata[OUT_DATA_W-1:OUT_FIELDS_W] !== '0)
          report_mismatch("padding", '0, out_tdata[OUT_DATA_W-1:OUT_FIELDS_W]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---- tests ----

  task automatic test_directed();
    sender_idle_pct = 12;
    receiver_idle_pct = 68;
    // fill all four frames, then hit and evict in LRU order
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h0000);
    send_page(16'h1234);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h8001);
    // shrink to two frames: upper frames are skipped but keep their pages
    write_frame_count(3'd2);
    send_page(16'hAAAA);
    send_page(16'h7FFE);
    send_page(16'hAAAA);
    // zero acts as one frame
    write_frame_count(3'd0);
    send_page(16'h0F0F);
    send_page(16'h0F0F);
    send_page(16'hF0F0);
    // above the frame count acts as all frames
    write_frame_count(3'd7);
    send_page(16'hAAAA);
    send_page(16'hF0F0);
    send_page(16'h0001);
    send_page(16'h8000);
    write_frame_count(3'd1);
    send_page(16'h4242);
    send_page(16'h2424);
    write_frame_count(3'd4);
    send_page(16'h2424);
    send_page(16'h4242);
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int item_total);
    int sent;
    int segment;
    int run_length;
    sent = 0;
    segment = 0;
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    while (sent < item_total) begin
      case (segment % 4)
        0:       write_frame_count(3'd4);
        1:       write_frame_count(3'd1);
        default: write_frame_count(CFG_W'($urandom_range(0, 7)));
      endcase
      refresh_hot_pages();
      run_length = $urandom_range(30, 70);
      for (int i = 0; i < run_length; i++)
        send_page(pick_page());
      sent += run_length;
      segment++;
    end
    wait_all_results();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_frame_count(3'd3);
    refresh_hot_pages();
    // sink held off: the unit fills and stalls its input
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 30; i++)
      send_page(pick_page());
    wait_all_results();
  endtask

  initial begin
    clear_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(12, 68, 400);
    test_random_traffic(68, 12, 400);
    test_backpressure();
    test_random_traffic(0, 0, 400);
    wait_all_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lru_pkg.sv
src/lru_ctrl.sv
src/lru_dp.sv
src/lru_page_replacement_unit.sv
bench/testbench.sv
